// File: rtl/lsqd_pkg.sv
package lsqd_pkg;

    localparam int LSQD_DEPTH = 16;

    // queue_limit value after reset
    localparam logic [4:0] LSQD_LIMIT_RESET = 5'd16;

    // command codes
    localparam logic [2:0] CMD_RESERVE = 3'd0;
    localparam logic [2:0] CMD_INSERT  = 3'd1;
    localparam logic [2:0] CMD_MARK_S  = 3'd2;
    localparam logic [2:0] CMD_MARK_C  = 3'd3;
    localparam logic [2:0] CMD_QUERY   = 3'd4;

    // status codes
    localparam logic [1:0] STAT_DONE     = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [1:0] STAT_NOSPACE  = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [4:0]  count;
        logic [63:0] addr;
        logic [15:0] context_id;
        logic [15:0] node_id;
        logic        is_store;
    } t_lsqd_in;

    typedef struct packed {
        logic       ok;
        logic       may_issue;
        logic [1:0] status;
    } t_lsqd_out;

    // one stored queue entry
    typedef struct packed {
        logic [63:0] addr;
        logic [15:0] context_id;
        logic [15:0] node_id;
        logic        is_store;
    } t_entry;

    // comparator flags
    typedef struct packed {
        logic key_eq;
        logic key_gt;
        logic addr_eq;
    } t_cmp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_COUNT,
        ST_FIND,
        ST_QUERY,
        ST_RESP
    } t_state;

endpackage

// File: rtl/lsqd_cmp.sv
module lsqd_cmp (
    input  lsqd_pkg::t_entry i_entry,
    input  logic [15:0]      i_context_id,
    input  logic [15:0]      i_node_id,
    input  logic [63:0]      i_addr,
    output lsqd_pkg::t_cmp   o_cmp
);
    import lsqd_pkg::*;

    logic ctx_eq;

    assign ctx_eq         = (i_entry.context_id == i_context_id);
    assign o_cmp.key_eq   = ctx_eq && (i_entry.node_id == i_node_id);
    // context is the major key, node the minor one
    assign o_cmp.key_gt   = ctx_eq ? (i_entry.node_id > i_node_id)
                                   : (i_entry.context_id > i_context_id);
    assign o_cmp.addr_eq  = (i_entry.addr == i_addr);

endmodule

// File: rtl/load_store_queue_disambiguation.sv
// Program-ordered load/store queue with memory disambiguation. Each input beat
// carries one command (reserve, insert, mark started, mark completed, query) and
// yields exactly one result beat (ok, may_issue, status). The block handles one
// command at a time: o_in_ready is high only while it is idle, and a finished
// result sits in an output register, so the next command is taken while that
// result still waits. Insert, unknown commands and a reserve that fits pass from
// the dispatch state straight to the result state. Mark locates the entry by
// walking from the head; a query first locates the entry and then walks the older
// entries. A reserve that must retire walks the completed run at the head, one
// entry a cycle. The find and query walks are paced by the entry memory's single
// registered read port, which feeds one shared key/address comparator one entry
// per cycle. queue_limit may only be written while no command is in flight;
// values above DEPTH act as DEPTH.
module load_store_queue_disambiguation #(
    parameter int DEPTH = lsqd_pkg::LSQD_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lsqd_pkg::t_lsqd_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lsqd_pkg::t_lsqd_out o_out_data
);
    import lsqd_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    // compare width, wide enough for occupancy + count
    localparam int CW    = ((OCC_W > 5) ? OCC_W : 5) + 1;

    // slot of position pos from the head; pos <= DEPTH so one wrap suffices
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [OCC_W-1:0] pos);
        logic [OCC_W:0] sum;
        sum = (OCC_W+1)'(head) + (OCC_W+1)'(pos);
        if (sum >= (OCC_W+1)'(DEPTH)) begin
            sum = sum - (OCC_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // sequencer and queue state
    t_state            r_state, n_state;
    logic [4:0]        r_limit;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [OCC_W-1:0]  r_occ, n_occ;
    logic [DEPTH-1:0]  r_started, n_started;
    logic [DEPTH-1:0]  r_completed, n_completed;

    // latched command
    t_lsqd_in          r_in;

    // walk pointers: read issue side and check side (a registered copy of the read side)
    logic [OCC_W-1:0]  r_rd_pos, n_rd_pos;
    logic              r_chk_v, n_chk_v;
    logic [OCC_W-1:0]  r_chk_pos, n_chk_pos;
    logic [IDX_W-1:0]  r_chk_slot, n_chk_slot;

    // the located entry
    logic [OCC_W-1:0]  r_me_pos, n_me_pos;
    logic [63:0]       r_my_addr, n_my_addr;
    logic              r_my_store, n_my_store;

    // pending result and output register
    t_lsqd_out         r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_lsqd_out         r_out, n_out;

    // entry memory, one write and one registered read port
    t_entry            r_mem [DEPTH];
    t_entry            r_rd_data;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    t_entry            mem_wdata;

    logic [IDX_W-1:0]  rd_slot;
    logic              rd_issue;
    logic [CW-1:0]     eff_lim;
    logic              fits, full;
    logic              cnt_stop, cnt_enough, cnt_retire;
    logic              walk_dry, find_hit;
    logic              qry_pass, qry_haz, qry_done;
    logic              out_free;
    t_cmp              cmp;

    // shared comparator: walked entry against the command's key and the
    // located entry's address
    lsqd_cmp u_cmp (
        .i_entry      (r_rd_data),
        .i_context_id (r_in.context_id),
        .i_node_id    (r_in.node_id),
        .i_addr       (r_my_addr),
        .o_cmp        (cmp)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign eff_lim  = (r_limit > 5'(DEPTH > 31 ? 31 : DEPTH)) && (DEPTH < 32)
                      ? CW'(DEPTH) : CW'(r_limit);
    assign fits     = (CW'(r_occ) + CW'(r_in.count)) <= eff_lim;
    assign full     = CW'(r_occ) >= eff_lim;

    assign rd_slot  = slot_of(r_head, r_rd_pos);
    assign rd_issue = (r_rd_pos != r_occ);

    // reserve: run of completed entries at the head
    assign cnt_stop   = !rd_issue || !r_completed[rd_slot];
    assign cnt_enough = (CW'(r_rd_pos) + CW'(1)) > CW'(r_in.count);
    assign cnt_retire = cnt_stop ? (CW'(r_rd_pos) > CW'(r_in.count)) : cnt_enough;

    // nothing left to read and nothing to check
    assign walk_dry = !r_chk_v && !rd_issue;
    assign find_hit = r_chk_v && cmp.key_eq;

    // query: stop at the entry itself or at a younger key; otherwise look
    // for an ordering hazard
    assign qry_pass = r_chk_v && ((r_chk_pos == r_me_pos) || cmp.key_gt);
    assign qry_haz  = r_chk_v && !qry_pass && (r_my_store || r_rd_data.is_store)
                      && (!r_started[r_chk_slot]
                          || (!r_completed[r_chk_slot] && cmp.addr_eq));
    assign qry_done = qry_pass || qry_haz || walk_dry;

    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (r_in.command) inside
                    CMD_RESERVE: n_state = fits ? ST_RESP : ST_COUNT;
                    CMD_INSERT:  n_state = ST_RESP;
                    CMD_MARK_S, CMD_MARK_C, CMD_QUERY: n_state = ST_FIND;
                    default:     n_state = ST_RESP;
                endcase
            end
            ST_COUNT: begin
                if (cnt_stop || cnt_enough) begin
                    n_state = ST_RESP;
                end
            end
            ST_FIND: begin
                if (find_hit) begin
                    n_state = (r_in.command == CMD_QUERY) ? ST_QUERY : ST_RESP;
                end else if (walk_dry) begin
                    n_state = ST_RESP;
                end
            end
            ST_QUERY: begin
                if (qry_done) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_head      = r_head;
        n_occ       = r_occ;
        n_started   = r_started;
        n_completed = r_completed;
        n_rd_pos    = r_rd_pos;
        n_chk_v     = 1'b0;
        n_chk_pos   = r_chk_pos;
        n_chk_slot  = r_chk_slot;
        n_me_pos    = r_me_pos;
        n_my_addr   = r_my_addr;
        n_my_store  = r_my_store;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = slot_of(r_head, r_occ);
        mem_wdata   = '{addr: r_in.addr, context_id: r_in.context_id,
                        node_id: r_in.node_id, is_store: r_in.is_store};

        unique case (r_state)
            ST_IDLE: ;
            ST_DISPATCH: begin
                n_rd_pos = '0;
                n_res    = '{ok: 1'b0, may_issue: 1'b0, status: STAT_DONE};
                unique case (r_in.command) inside
                    CMD_RESERVE: begin
                        if (fits) begin
                            n_res.ok = 1'b1;
                        end
                    end
                    CMD_INSERT: begin
                        if (full) begin
                            n_res.status = STAT_FULL;
                        end else begin
                            mem_we                 = 1'b1;
                            n_started[mem_waddr]   = 1'b0;
                            n_completed[mem_waddr] = 1'b0;
                            n_occ                  = r_occ + OCC_W'(1);
                            n_res.ok               = 1'b1;
                        end
                    end
                    CMD_MARK_S, CMD_MARK_C, CMD_QUERY: ;
                    default: ;
                endcase
            end
            ST_COUNT: begin
                if (cnt_stop || cnt_enough) begin
                    if (cnt_retire) begin
                        // retired slots get fresh bits on their next insert
                        n_head   = slot_of(r_head, OCC_W'(r_in.count));
                        n_occ    = r_occ - OCC_W'(r_in.count);
                        n_res.ok = 1'b1;
                    end else begin
                        n_res.status = STAT_NOSPACE;
                    end
                end else begin
                    n_rd_pos = r_rd_pos + OCC_W'(1);
                end
            end
            ST_FIND, ST_QUERY: begin
                n_rd_pos   = r_rd_pos + OCC_W'(rd_issue);
                n_chk_v    = rd_issue;
                n_chk_pos  = r_rd_pos;
                n_chk_slot = rd_slot;
                if (r_state == ST_FIND) begin
                    if (find_hit) begin
                        n_me_pos   = r_chk_pos;
                        n_my_addr  = r_rd_data.addr;
                        n_my_store = r_rd_data.is_store;
                        n_res.ok   = 1'b1;
                        if (r_in.command == CMD_MARK_S) begin
                            n_started[r_chk_slot] = 1'b1;
                        end else if (r_in.command == CMD_MARK_C) begin
                            n_completed[r_chk_slot] = 1'b1;
                        end
                        // restart the walk from the head for a query
                        n_rd_pos = '0;
                        n_chk_v  = 1'b0;
                    end else if (walk_dry) begin
                        n_res.status = STAT_NOTFOUND;
                    end
                end else if (qry_done) begin
                    n_res.may_issue = !qry_haz;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_limit     <= LSQD_LIMIT_RESET;
            r_head      <= '0;
            r_occ       <= '0;
            r_started   <= '0;
            r_completed <= '0;
            r_chk_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_head      <= n_head;
            r_occ       <= n_occ;
            r_started   <= n_started;
            r_completed <= n_completed;
            r_chk_v     <= n_chk_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_in <= i_in_data;
        end
        r_rd_pos   <= n_rd_pos;
        r_chk_pos  <= n_chk_pos;
        r_chk_slot <= n_chk_slot;
        r_me_pos   <= n_me_pos;
        r_my_addr  <= n_my_addr;
        r_my_store <= n_my_store;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_slot];
    end

endmodule

// File: rtl/lsqd_checker.sv
module lsqd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_cfg_we,
    input logic [4:0]          i_cfg_data,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input lsqd_pkg::t_lsqd_in  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input lsqd_pkg::t_lsqd_out o_out_data
);
    import lsqd_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // one command in flight at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after an accepted beat");

    // may_issue only comes with a successful query
    a_may_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.may_issue |-> o_out_data.ok
            && (o_out_data.status == STAT_DONE))
        else $error("may_issue without success");

    // any failure status means not ok
    a_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != STAT_DONE) |-> !o_out_data.ok)
        else $error("failure status with ok set");

endmodule

bind load_store_queue_disambiguation lsqd_checker u_lsqd_checker (.*);
